### rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared codes and field widths for the timer slot pool.
// ----------------------------------------------------------------------------
package tsp_pkg;

   // request codes carried on req_tuser
   localparam logic [1:0] REQ_TICK     = 2'd0;
   localparam logic [1:0] REQ_ONE_SHOT = 2'd1;
   localparam logic [1:0] REQ_PERIODIC = 2'd2;
   localparam logic [1:0] REQ_CLEAR    = 2'd3;

   // result kinds carried on rsp_tuser
   localparam logic [1:0] KIND_STARTED   = 2'd0;
   localparam logic [1:0] KIND_EXHAUSTED = 2'd1;
   localparam logic [1:0] KIND_CLEARED   = 2'd2;
   localparam logic [1:0] KIND_FIRED     = 2'd3;

   // fixed field widths on the stream ports
   localparam int COUNT_W = 32;
   localparam int TAG_W   = 16;
   localparam int SLOT_W  = 4;

   // at most this many fire results are reported for one tick
   localparam logic [4:0] MAX_FIRES = 5'd16;

endpackage

### rtl/tsp_slot_mem.sv
// ----------------------------------------------------------------------------
// tsp_slot_mem
// Per-slot store of remaining count, reload period and event tag: one write
// port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsp_slot_mem #(
   parameter int POOL_SIZE  = 16,
   parameter int COUNT_BITS = 32,
   parameter int TAG_BITS   = 16,
   parameter int IDX_BITS   = 4
) (
   input  logic                  clock,
   // write port: remaining alone, or all three fields
   input  logic                  wr_rem_en,
   input  logic                  wr_all_en,
   input  logic [IDX_BITS-1:0]   wr_addr,
   input  logic [COUNT_BITS-1:0] wr_rem,
   input  logic [COUNT_BITS-1:0] wr_reload,
   input  logic [TAG_BITS-1:0]   wr_tag,
   // read port
   input  logic                  rd_en,
   input  logic [IDX_BITS-1:0]   rd_addr,
   output logic [COUNT_BITS-1:0] rd_rem,
   output logic [COUNT_BITS-1:0] rd_reload,
   output logic [TAG_BITS-1:0]   rd_tag
);

   logic [COUNT_BITS-1:0] rem_mem    [POOL_SIZE];
   logic [COUNT_BITS-1:0] reload_mem [POOL_SIZE];
   logic [TAG_BITS-1:0]   tag_mem    [POOL_SIZE];

   // write
   always_ff @(posedge clock) begin
      if (wr_rem_en || wr_all_en) begin
         rem_mem[wr_addr] <= wr_rem;
      end
      if (wr_all_en) begin
         reload_mem[wr_addr] <= wr_reload;
         tag_mem[wr_addr]    <= wr_tag;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_rem    <= rem_mem[rd_addr];
         rd_reload <= reload_mem[rd_addr];
         rd_tag    <= tag_mem[rd_addr];
      end
   end

endmodule

### rtl/timer_slot_pool.sv
// ----------------------------------------------------------------------------
// timer_slot_pool
// Pool of countdown timer slots with one-shot and periodic start, clear and
// tick requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the req_ stream, one transaction per request; the
//   request code is on req_tuser. Results leave on the rsp_ stream; rsp_tlast
//   marks the final result caused by one request. A tick that fires nothing
//   and a clear of a slot number beyond the pool give no result.
//   The block takes one request at a time; req_tready is low while it works.
//   A tick walks the slots through the shared decrement/compare unit, one
//   slot a cycle over the single memory read port while no stall holds it.
//   A start scans the active bits one slot a cycle for the lowest free one
//   and then answers through the output register.
//   A clear answers through the output register as well.
//   Results pass through an output register; while the receiver holds
//   rsp_tready low, the block keeps one further fire result pending and then
//   pauses its walk until the register drains.
//   Reset frees every slot and empties the output register.
// ----------------------------------------------------------------------------
module timer_slot_pool #(
   parameter int POOL_SIZE  = 16,
   parameter int COUNT_BITS = 32,
   parameter int TAG_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // count[31:0], event_tag[47:32], slot[51:48], zero
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // slot_out[3:0], tag_out[19:4], zero
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast
);

   localparam int IDX_BITS = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int CNT_BITS = IDX_BITS + 1;
   localparam logic [CNT_BITS-1:0] SCAN_END  = CNT_BITS'(POOL_SIZE);
   localparam logic [CNT_BITS-1:0] SCAN_LAST = CNT_BITS'(POOL_SIZE - 1);
   localparam logic [6:0]          SLOT_LIM  = 7'(POOL_SIZE);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TICK  = 3'd1;
   localparam logic [2:0] ST_FLUSH = 3'd2;
   localparam logic [2:0] ST_ALLOC = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   // control state
   logic [2:0]           state_ff, state_in;
   logic [POOL_SIZE-1:0] act_ff, act_in;
   logic [CNT_BITS-1:0]  scan_ff, scan_in;
   logic                 eval_vld_ff, eval_vld_in;
   logic [4:0]           fires_ff, fires_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic                 rsp_vld_ff, rsp_vld_in;

   // payload
   logic [IDX_BITS-1:0]      eval_idx_ff, eval_idx_in;
   logic [1:0]               pend_kind_ff, pend_kind_in;
   logic [tsp_pkg::SLOT_W-1:0] pend_slot_ff, pend_slot_in;
   logic [tsp_pkg::TAG_W-1:0]  pend_tag_ff, pend_tag_in;
   logic [1:0]               rsp_kind_ff, rsp_kind_in;
   logic [tsp_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [tsp_pkg::TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [COUNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [TAG_BITS-1:0]      tag_ff, tag_in;
   logic                     periodic_ff, periodic_in;

   // memory interface
   logic                  wr_rem_en, wr_all_en, rd_en;
   logic [IDX_BITS-1:0]   wr_addr, rd_addr;
   logic [COUNT_BITS-1:0] wr_rem, wr_reload, rd_rem, rd_reload;
   logic [TAG_BITS-1:0]   rd_tag;

   // request fields
   logic [tsp_pkg::COUNT_W-1:0] req_count;
   logic [tsp_pkg::TAG_W-1:0]   req_tag;
   logic [tsp_pkg::SLOT_W-1:0]  req_slot;
   logic [TAG_BITS+tsp_pkg::TAG_W-1:0]        req_tag_ext;
   logic [IDX_BITS+tsp_pkg::SLOT_W-1:0]       req_slot_ext;
   logic [IDX_BITS+tsp_pkg::SLOT_W-1:0]       eval_slot_ext;
   logic [IDX_BITS+tsp_pkg::SLOT_W-1:0]       scan_slot_ext;
   logic [TAG_BITS+tsp_pkg::TAG_W-1:0]        rd_tag_ext;
   logic [IDX_BITS-1:0]   scan_idx;
   logic [IDX_BITS-1:0]   clr_idx;
   logic                  req_acc, rsp_free;
   logic                  eval_act, fire, report, stall;
   logic                  rsp_load;

   assign req_count = req_tdata[31:0];
   assign req_tag   = req_tdata[47:32];
   assign req_slot  = req_tdata[51:48];

   // width adaptation between slot indices, tags and the fixed port fields
   assign req_tag_ext   = {{TAG_BITS{1'b0}}, req_tag};
   assign req_slot_ext  = {{IDX_BITS{1'b0}}, req_slot};
   assign clr_idx       = req_slot_ext[IDX_BITS-1:0];
   assign scan_idx      = scan_ff[IDX_BITS-1:0];
   assign eval_slot_ext = {{tsp_pkg::SLOT_W{1'b0}}, eval_idx_ff};
   assign scan_slot_ext = {{tsp_pkg::SLOT_W{1'b0}}, scan_idx};
   assign rd_tag_ext    = {{tsp_pkg::TAG_W{1'b0}}, rd_tag};

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_free   = !rsp_vld_ff || rsp_tready;

   // shared compare unit: does the slot under evaluation fire this tick
   assign eval_act = act_ff[eval_idx_ff];
   assign fire     = eval_vld_ff && eval_act && (rd_rem[COUNT_BITS-1:1] == '0);
   assign report   = fire && (fires_ff < tsp_pkg::MAX_FIRES);
   assign stall    = report && pend_vld_ff && !rsp_free;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      scan_in      = scan_ff;
      eval_vld_in  = eval_vld_ff;
      eval_idx_in  = eval_idx_ff;
      fires_in     = fires_ff;
      pend_vld_in  = pend_vld_ff;
      pend_kind_in = pend_kind_ff;
      pend_slot_in = pend_slot_ff;
      pend_tag_in  = pend_tag_ff;
      cnt_in       = cnt_ff;
      tag_in       = tag_ff;
      periodic_in  = periodic_ff;
      rsp_load     = 1'b0;
      rsp_last_in  = rsp_last_ff;
      wr_rem_en    = 1'b0;
      wr_all_en    = 1'b0;
      wr_addr      = eval_idx_ff;
      wr_rem       = rd_rem - COUNT_BITS'(1);
      wr_reload    = cnt_ff;
      rd_en        = 1'b0;
      rd_addr      = scan_idx;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cnt_in      = req_count[COUNT_BITS-1:0];
               tag_in      = req_tag_ext[TAG_BITS-1:0];
               periodic_in = (req_tuser == tsp_pkg::REQ_PERIODIC);
               scan_in     = '0;
               unique case (req_tuser)
                  tsp_pkg::REQ_TICK: begin
                     fires_in    = '0;
                     eval_vld_in = 1'b0;
                     state_in    = ST_TICK;
                  end
                  tsp_pkg::REQ_ONE_SHOT, tsp_pkg::REQ_PERIODIC: begin
                     state_in = ST_ALLOC;
                  end
                  tsp_pkg::REQ_CLEAR: begin
                     if ({3'b000, req_slot} < SLOT_LIM) begin
                        act_in[clr_idx] = 1'b0;
                        pend_kind_in    = tsp_pkg::KIND_CLEARED;
                        pend_slot_in    = req_slot;
                        pend_tag_in     = '0;
                        state_in        = ST_RESP;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_TICK: begin
            if (!stall) begin
               // evaluate the slot whose data sits in the read register
               if (eval_vld_ff && eval_act) begin
                  if (fire) begin
                     if (rd_reload != '0) begin
                        wr_rem    = rd_reload;
                        wr_rem_en = 1'b1;
                     end else begin
                        act_in[eval_idx_ff] = 1'b0;
                     end
                     if (report) begin
                        // the pending fire moves on only when a newer one follows it
                        rsp_load     = pend_vld_ff;
                        if (pend_vld_ff) begin
                           rsp_last_in = 1'b0;
                        end
                        pend_vld_in  = 1'b1;
                        pend_kind_in = tsp_pkg::KIND_FIRED;
                        pend_slot_in = eval_slot_ext[tsp_pkg::SLOT_W-1:0];
                        pend_tag_in  = rd_tag_ext[tsp_pkg::TAG_W-1:0];
                        fires_in     = fires_ff + 5'd1;
                     end
                  end else begin
                     wr_rem_en = 1'b1;
                  end
               end
               // fetch the next slot
               if (scan_ff < SCAN_END) begin
                  rd_en       = 1'b1;
                  eval_idx_in = scan_idx;
                  eval_vld_in = 1'b1;
                  scan_in     = scan_ff + CNT_BITS'(1);
               end else begin
                  eval_vld_in = 1'b0;
                  if (!eval_vld_ff) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end

         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_load    = 1'b1;
               rsp_last_in = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         ST_ALLOC: begin
            // lowest free slot, one slot a cycle
            if (!act_ff[scan_idx]) begin
               act_in[scan_idx] = 1'b1;
               wr_all_en    = 1'b1;
               wr_addr      = scan_idx;
               wr_rem       = cnt_ff;
               wr_reload    = periodic_ff ? cnt_ff : '0;
               pend_kind_in = tsp_pkg::KIND_STARTED;
               pend_slot_in = scan_slot_ext[tsp_pkg::SLOT_W-1:0];
               pend_tag_in  = '0;
               state_in     = ST_RESP;
            end else if (scan_ff == SCAN_LAST) begin
               pend_kind_in = tsp_pkg::KIND_EXHAUSTED;
               pend_slot_in = '0;
               pend_tag_in  = '0;
               state_in     = ST_RESP;
            end else begin
               scan_in = scan_ff + CNT_BITS'(1);
            end
         end

         ST_RESP: begin
            if (rsp_free) begin
               rsp_load    = 1'b1;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_kind_in = rsp_load ? pend_kind_ff : rsp_kind_ff;
      rsp_slot_in = rsp_load ? pend_slot_ff : rsp_slot_ff;
      rsp_tag_in  = rsp_load ? pend_tag_ff  : rsp_tag_ff;
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         act_ff      <= '0;
         scan_ff     <= '0;
         eval_vld_ff <= 1'b0;
         fires_ff    <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         act_ff      <= act_in;
         scan_ff     <= scan_in;
         eval_vld_ff <= eval_vld_in;
         fires_ff    <= fires_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      eval_idx_ff  <= eval_idx_in;
      pend_kind_ff <= pend_kind_in;
      pend_slot_ff <= pend_slot_in;
      pend_tag_ff  <= pend_tag_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_last_ff  <= rsp_last_in;
      cnt_ff       <= cnt_in;
      tag_ff       <= tag_in;
      periodic_ff  <= periodic_in;
   end

   // slot store
   tsp_slot_mem #(
      .POOL_SIZE  (POOL_SIZE),
      .COUNT_BITS (COUNT_BITS),
      .TAG_BITS   (TAG_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_slot_mem (
      .clock     (clock),
      .wr_rem_en (wr_rem_en),
      .wr_all_en (wr_all_en),
      .wr_addr   (wr_addr),
      .wr_rem    (wr_rem),
      .wr_reload (wr_reload),
      .wr_tag    (tag_ff),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_rem    (rd_rem),
      .rd_reload (rd_reload),
      .rd_tag    (rd_tag)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0000, rsp_tag_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
